// ----- rtl/tcce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cursor engine
// sequencer states, item modes and the character codes the console treats
// specially
// ----------------------------------------------------------------------------
package tcce_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUT,
    S_SCROLL,
    S_SCROLL_END,
    S_FILL,
    S_RDWAIT,
    S_DONE
  } tcce_state_t;

  localparam logic [1:0] MODE_CHAR  = 2'd0;
  localparam logic [1:0] MODE_SETCUR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [7:0] CODE_NUL   = 8'h00;
  localparam logic [7:0] CODE_LF    = 8'h0a;
  localparam logic [7:0] CODE_CR    = 8'h0d;
  localparam logic [7:0] CODE_SPACE = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h07;

endpackage

// ----- rtl/tcce_addr_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_addr_unit: cursor to linear cell index
// one 8x8 multiply plus add, shared by the cell write and the position report
// ----------------------------------------------------------------------------
module tcce_addr_unit #(
  parameter int COLUMNS = 80
) (
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  output logic [15:0] index
);

  logic [15:0] prod;

  assign prod  = {8'd0, row} * 16'(COLUMNS);
  // wraps to 16 bits like the reported position
  assign index = prod + {8'd0, col};

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine: character-cell text console with a cursor
// the result strobe follows S_EXEC and S_DONE for cr, lf, nul, set cursor and
//   out-of-range read, with S_RDWAIT or S_PUT between for a cell read or store
// scroll moves the cells up a row and blanks the bottom row, one cell move or
//   fill per cycle over the single write port; clear fills every cell with
//   spaces; results cannot be stalled; busy drops in the strobe cycle, and no
//   new item is taken before then; after reset a clearing pass fills the screen
//   with spaces of attribute 7 while busy is high; config writes are taken when idle
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_target_row,
  input  logic [7:0]  in_target_col,
  input  logic [10:0] in_cell_index,
  // result channel, one cycle strobe, no back pressure
  output logic        out_strobe,
  output logic [15:0] out_cursor_position,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr,
  // attribute register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // geometry
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;   // cells shifted up by a scroll
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);

  function automatic logic [7:0] next_row(input logic [7:0] r);
    next_row = (r == 8'hff) ? 8'hff : r + 8'd1;
  endfunction

  // sequencer state
  tcce_state_t state_r, state_nxt;
  tcce_state_t ret_r, ret_nxt;          // where a fill sweep returns to

  // cursor and attribute
  logic [7:0] row_r, row_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] attr_r;

  // sweep counter and fill value
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   fill_val_r, fill_val_nxt;

  // scroll copy pipeline: read one row ahead, write in the next cycle
  logic          copy_pend_r, copy_pend_nxt;
  logic [AW-1:0] copy_addr_r, copy_addr_nxt;

  // latched item fields
  logic [1:0]  m_mode_r;
  logic [7:0]  m_char_r;
  logic [7:0]  m_trow_r;
  logic [7:0]  m_tcol_r;
  logic [10:0] m_index_r;

  // read result and output registers
  logic [7:0]  rchar_r, rchar_nxt;
  logic [7:0]  rattr_r, rattr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pos_r, out_pos_nxt;

  // cell memory: low byte character, high byte attribute
  logic [15:0]   mem [CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [15:0]   rd_data_r;

  // shared index unit, always fed with the current cursor
  logic [15:0] cur_index;

  // wrap resolution for a printable byte
  logic       wrap;
  logic [7:0] wrap_row;
  logic [7:0] wrap_col;

  logic accept;

  tcce_addr_unit #(
    .COLUMNS (COLUMNS)
  ) u_addr (
    .row   (row_r),
    .col   (col_r),
    .index (cur_index)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  // attribute changes only between items so a whole item sees one value
  assign cfg_ready = (state_r == S_IDLE);

  assign out_strobe          = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = rchar_r;
  assign out_read_attr       = rattr_r;

  assign wrap     = (col_r >= 8'(COLUMNS));
  assign wrap_row = wrap ? next_row(row_r) : row_r;
  assign wrap_col = wrap ? 8'd0 : col_r;

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    fill_val_nxt  = fill_val_r;
    copy_pend_nxt = 1'b0;
    copy_addr_nxt = copy_addr_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    mem_ra        = AW'(m_index_r);
    // a pending scroll copy owns the write port
    mem_we        = copy_pend_r;
    mem_wa        = copy_addr_r;
    mem_wd        = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rchar_nxt = 8'd0;
          rattr_nxt = 8'd0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (m_mode_r)
          MODE_CHAR: begin
            if (m_char_r == CODE_NUL) begin
              state_nxt = S_DONE;
            end else if (m_char_r == CODE_CR) begin
              col_nxt   = 8'd0;
              state_nxt = S_DONE;
            end else if (m_char_r == CODE_LF) begin
              col_nxt   = 8'd0;
              row_nxt   = next_row(row_r);
              state_nxt = S_DONE;
            end else if (wrap_row >= 8'(ROWS)) begin
              // off the bottom: scroll, cursor to start of last row
              row_nxt   = 8'(ROWS - 1);
              col_nxt   = 8'd0;
              cnt_nxt   = '0;
              state_nxt = S_SCROLL;
            end else begin
              row_nxt   = wrap_row;
              col_nxt   = wrap_col;
              state_nxt = S_PUT;
            end
          end
          MODE_SETCUR: begin
            row_nxt   = m_trow_r;
            col_nxt   = m_tcol_r;
            state_nxt = S_DONE;
          end
          MODE_READ: begin
            // read issued here at the latched index, data next cycle
            if (17'(m_index_r) < 17'(CELL_COUNT)) begin
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          MODE_CLEAR: begin
            row_nxt      = 8'd0;
            col_nxt      = 8'd0;
            cnt_nxt      = '0;
            fill_val_nxt = {attr_r, CODE_SPACE};
            ret_nxt      = S_DONE;
            state_nxt    = S_FILL;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = cur_index[AW-1:0];
        mem_wd    = {attr_r, m_char_r};
        col_nxt   = col_r + 8'd1;
        state_nxt = S_DONE;
      end

      S_SCROLL: begin
        mem_ra        = AW'(cnt_r + CW'(COLUMNS));
        copy_pend_nxt = 1'b1;
        copy_addr_nxt = cnt_r[AW-1:0];
        if (cnt_r == CW'(MOVE_COUNT - 1)) begin
          state_nxt = S_SCROLL_END;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      S_SCROLL_END: begin
        // last copy drains this cycle, then blank the bottom row
        cnt_nxt      = CW'(MOVE_COUNT);
        fill_val_nxt = {attr_r, CODE_SPACE};
        ret_nxt      = S_PUT;
        state_nxt    = S_FILL;
      end

      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        mem_wd = fill_val_r;
        if (cnt_r == CW'(CELL_COUNT - 1)) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      S_RDWAIT: begin
        rchar_nxt = rd_data_r[7:0];
        rattr_nxt = rd_data_r[15:8];
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = cur_index;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers; reset starts the clearing pass with attribute 7
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      fill_val_r  <= {RESET_ATTR, CODE_SPACE};
      row_r       <= 8'd0;
      col_r       <= 8'd0;
      attr_r      <= RESET_ATTR;
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      rchar_r     <= 8'd0;
      rattr_r     <= 8'd0;
      out_pos_r   <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      copy_pend_r <= copy_pend_nxt;
      out_valid_r <= out_valid_nxt;
      rchar_r     <= rchar_nxt;
      rattr_r     <= rattr_nxt;
      out_pos_r   <= out_pos_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_addr_r <= copy_addr_nxt;
    if (accept) begin
      m_mode_r  <= in_mode;
      m_char_r  <= in_char_code;
      m_trow_r  <= in_target_row;
      m_tcol_r  <= in_target_col;
      m_index_r <= in_cell_index;
    end
  end

  // cell memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // a result strobe only ever follows the done step
  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_DONE)
    else $error("result strobe without done step");

  // an accepted item makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a character store always lands on a cell of the screen
  a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT |-> (row_r < 8'(ROWS)) && (col_r < 8'(COLUMNS)))
    else $error("character store outside the screen");

  // scroll copies never collide with a fill or a store
  a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> (state_r == S_SCROLL) || (state_r == S_SCROLL_END))
    else $error("scroll copy outside the scroll steps");

endmodule

// ----- tb/tb_text_console_cursor_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine: self-checking bench for the text console
// drives console items (characters, cursor moves, cell reads, clears) under
// several attribute settings and idle patterns; a scoreboard keeps its own
// copy of the screen and cursor and checks every result strobe in order
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int QUIET_MAX  = 20000;   // well above the length of one scroll or clear
  localparam int PHASE_ITEMS = 450;

  // one result of the console: cursor after the item and the cell read back
  typedef struct packed {
    logic [15:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } cursor_report_t;

  // mirror of the console: screen, cursor and attribute, plus the reports
  // still owed by the block
  class console_scoreboard;
    logic [15:0]    cells [CELLS];
    logic [7:0]     cur_row;
    logic [7:0]     cur_col;
    logic [7:0]     attr;
    int             last_cell;
    int             errors;
    cursor_report_t awaited_reports [$];

    function new();
      attr      = RESET_ATTR;
      cur_row   = '0;
      cur_col   = '0;
      last_cell = 0;
      errors    = 0;
      foreach (cells[i]) cells[i] = {RESET_ATTR, CODE_SPACE};
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    function logic [7:0] bump_row(logic [7:0] r);
      return (r == 8'hff) ? r : r + 8'd1;
    endfunction

    // advance the mirror by one accepted item and queue its report
    function void note_item(logic [1:0] mode, logic [7:0] ch, logic [7:0] trow,
                            logic [7:0] tcol, logic [10:0] cidx);
      cursor_report_t rep;
      int             pos;
      rep = '0;
      case (mode)
        MODE_CHAR: begin
          if (ch == CODE_NUL) begin
            // ignored
          end else if (ch == CODE_CR) begin
            cur_col = '0;
          end else if (ch == CODE_LF) begin
            cur_col = '0;
            cur_row = bump_row(cur_row);
          end else begin
            if (cur_col >= COLUMNS) begin
              cur_col = '0;
              cur_row = bump_row(cur_row);
            end
            if (cur_row >= ROWS) begin
              // scroll up one row, blank last row with the current attribute
              for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
              for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = {attr, CODE_SPACE};
              cur_row = 8'(ROWS - 1);
              cur_col = '0;
            end
            last_cell = cur_row * COLUMNS + cur_col;
            cells[last_cell] = {attr, ch};
            cur_col = cur_col + 8'd1;
          end
        end
        MODE_SETCUR: begin
          cur_row = trow;
          cur_col = tcol;
        end
        MODE_READ: begin
          if (cidx < CELLS) begin
            rep.cell_char = cells[cidx][7:0];
            rep.cell_attr = cells[cidx][15:8];
          end
        end
        MODE_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CODE_SPACE};
          cur_row = '0;
          cur_col = '0;
        end
        default: begin
        end
      endcase
      pos = cur_row * COLUMNS + cur_col;
      rep.cursor_pos = pos[15:0];
      awaited_reports.push_back(rep);
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t want;
      if (awaited_reports.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected result pos=%0d char=%02h attr=%02h", $time,
                   got.cursor_pos, got.cell_char, got.cell_attr);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
            got.cell_attr !== want.cell_attr) begin
          if (errors < 10)
            $display("%0t: mismatch pos %0d/%0d char %02h/%02h attr %02h/%02h (exp/got)",
                     $time, want.cursor_pos, got.cursor_pos, want.cell_char,
                     got.cell_char, want.cell_attr, got.cell_attr);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_target_row = '0;
  logic [7:0]  in_target_col = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_strobe;
  logic [15:0] out_cursor_position;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  console_scoreboard sb = new();
  int quiet_cycles = 0;

  text_console_cursor_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_char_code       (in_char_code),
    .in_target_row      (in_target_row),
    .in_target_col      (in_target_col),
    .in_cell_index      (in_cell_index),
    .out_strobe         (out_strobe),
    .out_cursor_position(out_cursor_position),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: results are checked before a new item is noted on the same edge,
  // since a strobe here always belongs to the item taken earlier; an attribute
  // write on the same edge as an item already applies to that item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_report({out_cursor_position, out_read_char, out_read_attr});
      if (cfg_valid && cfg_ready)
        sb.attr = cfg_data;
      if (start && !busy)
        sb.note_item(in_mode, in_char_code, in_target_row, in_target_col, in_cell_index);
    end
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // present one item and hold it until taken; start stays high on return
  task automatic send_item(logic [1:0] mode, logic [7:0] ch, logic [7:0] trow,
                           logic [7:0] tcol, logic [10:0] cidx);
    start         <= 1'b1;
    in_mode       <= mode;
    in_char_code  <= ch;
    in_target_row <= trow;
    in_target_col <= tcol;
    in_cell_index <= cidx;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender holds off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // attribute write, only called with the block idle
  task automatic write_attr(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random item; text-heavy mix with cursor moves and reads near the
  // last stored cell so writes get read back
  task automatic random_item();
    int          pick;
    int          sub;
    logic [7:0]  ch;
    logic [7:0]  trow;
    logic [7:0]  tcol;
    logic [10:0] cidx;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    ch   = rand_byte();
    trow = rand_byte();
    tcol = rand_byte();
    cidx = 11'($urandom_range(2047));
    if (pick < 55) begin
      if (sub < 8)       ch = CODE_LF;
      else if (sub < 12) ch = CODE_CR;
      else if (sub < 15) ch = CODE_NUL;
      send_item(MODE_CHAR, ch, trow, tcol, cidx);
    end else if (pick < 70) begin
      if (sub < 80) begin
        trow = 8'($urandom_range(ROWS - 1));
        tcol = 8'($urandom_range(COLUMNS - 1));
      end else if (sub < 95) begin
        // around the bottom right corner, just on and just off screen
        trow = 8'($urandom_range(ROWS + 1, ROWS - 5));
        tcol = 8'($urandom_range(COLUMNS + 4, COLUMNS - 5));
      end
      send_item(MODE_SETCUR, ch, trow, tcol, cidx);
    end else if (pick < 97) begin
      if (sub < 40)      cidx = 11'(sb.last_cell);
      else if (sub < 50) cidx = 11'($urandom_range(CELLS - 1, CELLS - COLUMNS));
      send_item(MODE_READ, ch, trow, tcol, cidx);
    end else begin
      send_item(MODE_CLEAR, ch, trow, tcol, cidx);
    end
  endtask

  initial begin
    int         idle_pct [4];
    logic [7:0] attr_set [4];
    int         pause_at;

    idle_pct = '{0, 63, 0, 23};
    attr_set = '{8'hff, 8'h00, rand_byte(), rand_byte()};

    // reset, then let the power-up clearing pass finish
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // directed: reads of the reset screen, edge indexes and out-of-range reads
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'(CELLS - 1));
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'(CELLS));
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'd2047);
    // plain char, nul ignored, cr, lf, top code
    send_item(MODE_CHAR, 8'h41, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, CODE_NUL, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, CODE_CR, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, CODE_LF, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, 8'hff, rand_byte(), rand_byte(), 11'd0);
    // last column then wrap to the next row, read the wrapped char back
    send_item(MODE_SETCUR, rand_byte(), 8'd0, 8'(COLUMNS - 1), 11'd0);
    send_item(MODE_CHAR, 8'h78, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, 8'h79, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'(COLUMNS));
    // wrap off the bottom row forces a scroll
    send_item(MODE_SETCUR, rand_byte(), 8'(ROWS - 1), 8'(COLUMNS - 1), 11'd0);
    send_item(MODE_CHAR, 8'h61, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, 8'h62, rand_byte(), rand_byte(), 11'd0);
    // cursor at the far corner, lf saturates the row, next char scrolls
    send_item(MODE_SETCUR, rand_byte(), 8'hff, 8'hff, 11'd0);
    send_item(MODE_CHAR, CODE_LF, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_CHAR, 8'h7a, rand_byte(), rand_byte(), 11'd0);
    // column set past the right edge on the last row
    send_item(MODE_SETCUR, rand_byte(), 8'(ROWS - 1), 8'd200, 11'd0);
    send_item(MODE_CHAR, 8'h63, rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'(CELLS - COLUMNS));
    // clear and read back
    send_item(MODE_CLEAR, rand_byte(), rand_byte(), rand_byte(), 11'd0);
    send_item(MODE_READ, rand_byte(), rand_byte(), rand_byte(), 11'd0);

    // random phases, each under its own attribute and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      repeat (8) @(posedge clk);
      write_attr(attr_set[ph]);
      pause_at = $urandom_range(PHASE_ITEMS - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at || $urandom_range(99) == 0)
          drain();
        else if ($urandom_range(99) < idle_pct[ph])
          idle_cycles($urandom_range(8, 1));
        random_item();
      end
    end

    // wait out the remaining results, then watch for stray strobes
    drain();
    repeat (12) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
